FILE: rtl/core/lsis_pkg.sv
package lsis_pkg;

  // Number of license strings held in the character table.
  localparam int NUM_STRINGS = 3;

  // Saturation value of the elapsed tick counter.
  localparam logic [17:0] ELAPSED_MAX = 18'h3FFFF;

  // Saturation value of the qualify counter.
  localparam logic [7:0] QUALIFY_MAX = 8'hFF;

  // Register reset values.
  localparam logic [18:0] LEAD_IN_RST  = 19'd4500;
  localparam logic [15:0] PERIOD_RST   = 16'd13333;
  localparam logic [7:0]  HOLD_RST     = 8'd100;
  localparam logic [17:0] GAP_RST      = 18'd90000;
  localparam logic [5:0]  ORDER_RST    = 6'd36;
  localparam logic [1:0]  ACTIVE_RST   = 2'd3;

  // Register indexes on the configuration port (byte address / 4).
  typedef enum logic [2:0] {
    REG_LEAD_IN = 3'd0,
    REG_PERIOD  = 3'd1,
    REG_HOLD    = 3'd2,
    REG_GAP     = 3'd3,
    REG_ORDER   = 3'd4,
    REG_ACTIVE  = 3'd5
  } reg_idx_t;

  // Sequencer phase.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_WAIT_TX = 2'd1,
    PH_GAP     = 2'd2
  } phase_t;

  // Result event kinds.
  typedef enum logic {
    EV_CHAR = 1'b0,
    EV_END  = 1'b1
  } event_t;

  // Current register values as seen by the sequencer.
  typedef struct packed {
    logic [18:0] lead_in_sector;
    logic [15:0] period_us;
    logic [7:0]  hold_count;
    logic [17:0] gap_us;
    logic [5:0]  license_order;
    logic [1:0]  active_count;
  } cfg_t;

  // Results caused by one request: four characters of a string, an end event, or both.
  typedef struct packed {
    logic       chars;
    logic       end_ev;
    logic [1:0] sel;
  } bundle_t;

  // Character pos of license string sel: SCEA, SCEE, SCEI.
  function automatic logic [7:0] lic_char(input logic [1:0] sel, input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0: ch = 8'h53;
      2'd1: ch = 8'h43;
      2'd2: ch = 8'h45;
      default: begin
        case (sel)
          2'd0: ch = 8'h41;
          2'd1: ch = 8'h45;
          default: ch = 8'h49;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/core/lsis_in_if.sv
interface lsis_in_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] sector;
  logic               gfs_set;
  logic               soct_on;
  logic               disc_has_data;
  logic               tx_idle;

  modport source (
    output valid, sector, gfs_set, soct_on, disc_has_data, tx_idle,
    input  ready
  );

  modport sink (
    input  valid, sector, gfs_set, soct_on, disc_has_data, tx_idle,
    output ready
  );
endinterface

FILE: rtl/core/lsis_out_if.sv
interface lsis_out_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [7:0] char_byte;
  logic       last;

  modport source (
    output valid, event_kind, char_byte, last,
    input  ready
  );

  modport sink (
    input  valid, event_kind, char_byte, last,
    output ready
  );
endinterface

FILE: rtl/core/lsis_cfg.sv
module lsis_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output lsis_pkg::cfg_t      cfg
);

  lsis_pkg::cfg_t cfg_r;
  lsis_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [2:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        lsis_pkg::REG_LEAD_IN: cfg_nxt.lead_in_sector = pwdata[18:0];
        lsis_pkg::REG_PERIOD:  cfg_nxt.period_us      = pwdata[15:0];
        lsis_pkg::REG_HOLD:    cfg_nxt.hold_count     = pwdata[7:0];
        lsis_pkg::REG_GAP:     cfg_nxt.gap_us         = pwdata[17:0];
        lsis_pkg::REG_ORDER:   cfg_nxt.license_order  = pwdata[5:0];
        lsis_pkg::REG_ACTIVE:  cfg_nxt.active_count   = pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lead_in_sector <= lsis_pkg::LEAD_IN_RST;
      cfg_r.period_us      <= lsis_pkg::PERIOD_RST;
      cfg_r.hold_count     <= lsis_pkg::HOLD_RST;
      cfg_r.gap_us         <= lsis_pkg::GAP_RST;
      cfg_r.license_order  <= lsis_pkg::ORDER_RST;
      cfg_r.active_count   <= lsis_pkg::ACTIVE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read data mux.
  always_comb begin
    prdata = '0;
    unique case (idx)
      lsis_pkg::REG_LEAD_IN: prdata = {13'd0, cfg_r.lead_in_sector};
      lsis_pkg::REG_PERIOD:  prdata = {16'd0, cfg_r.period_us};
      lsis_pkg::REG_HOLD:    prdata = {24'd0, cfg_r.hold_count};
      lsis_pkg::REG_GAP:     prdata = {14'd0, cfg_r.gap_us};
      lsis_pkg::REG_ORDER:   prdata = {26'd0, cfg_r.license_order};
      lsis_pkg::REG_ACTIVE:  prdata = {30'd0, cfg_r.active_count};
      default:               prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/lsis_ctrl.sv
module lsis_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  lsis_in_if.sink           in_ch,
  input  lsis_pkg::cfg_t    cfg,
  input  logic              emit_ready,
  output logic              bundle_valid,
  output lsis_pkg::bundle_t bundle
);

  lsis_pkg::phase_t phase_r, phase_nxt;
  logic [17:0]      elapsed_r, elapsed_nxt;
  logic [7:0]       qualify_r, qualify_nxt;
  logic [2:0]       sidx_r, sidx_nxt;
  logic [17:0]      gap_r, gap_nxt;

  logic        in_fire;
  logic [19:0] sec_u;
  logic        sec_ok;
  logic        win_ok;
  logic        abort_cond;
  logic [17:0] elapsed_inc;
  logic [7:0]  qualify_inc;
  logic [17:0] gap_cur;
  logic [1:0]  cnt;
  logic [1:0]  slot;
  logic [1:0]  entry;
  logic [1:0]  sel;
  logic [2:0]  sidx_inc;
  logic [1:0]  sel_max;

  assign in_ch.ready = emit_ready;
  assign in_fire     = in_ch.valid && emit_ready;

  // Status decode for this request.
  assign sec_u      = in_ch.sector;
  assign sec_ok     = (sec_u != 20'd0) && !sec_u[19] && (sec_u[18:0] < cfg.lead_in_sector);
  assign win_ok     = sec_ok && in_ch.gfs_set && !in_ch.soct_on && in_ch.disc_has_data;
  assign abort_cond = !sec_ok || !in_ch.gfs_set || in_ch.soct_on;

  assign elapsed_inc = (elapsed_r == lsis_pkg::ELAPSED_MAX) ? elapsed_r : elapsed_r + 18'd1;
  assign qualify_inc = (qualify_r == lsis_pkg::QUALIFY_MAX) ? qualify_r : qualify_r + 8'd1;
  assign gap_cur     = (phase_r == lsis_pkg::PH_WAIT_TX) ? 18'd0 : gap_r;
  assign sidx_inc    = sidx_r + 3'd1;
  assign cnt         = (cfg.active_count == 2'd0) ? 2'd1 : cfg.active_count;
  assign sel_max     = 2'(lsis_pkg::NUM_STRINGS - 1);

  // Order slot: string index modulo the number of entries in use.
  always_comb begin
    case (cnt)
      2'd1: slot = 2'd0;
      2'd2: slot = {1'b0, sidx_r[0]};
      default: begin
        case (sidx_r)
          3'd0, 3'd3, 3'd6: slot = 2'd0;
          3'd1, 3'd4, 3'd7: slot = 2'd1;
          default:          slot = 2'd2;
        endcase
      end
    endcase
  end

  // Pick the order entry and clamp it to a valid string.
  always_comb begin
    case (slot)
      2'd0:    entry = cfg.license_order[1:0];
      2'd1:    entry = cfg.license_order[3:2];
      default: entry = cfg.license_order[5:4];
    endcase
    sel = (entry == 2'd3) ? 2'd2 : entry;
    if (sel > sel_max) begin
      sel = sel_max;
    end
  end

  // Next state and results for the accepted request.
  always_comb begin
    phase_nxt    = phase_r;
    elapsed_nxt  = elapsed_r;
    qualify_nxt  = qualify_r;
    sidx_nxt     = sidx_r;
    gap_nxt      = gap_r;
    bundle_valid = 1'b0;
    bundle       = '{chars: 1'b0, end_ev: 1'b0, sel: sel};
    if (in_fire) begin
      unique case (phase_r)
        lsis_pkg::PH_WAIT_TX, lsis_pkg::PH_GAP: begin
          if (phase_r == lsis_pkg::PH_GAP || in_ch.tx_idle) begin
            if (gap_cur < cfg.gap_us) begin
              if (abort_cond) begin
                bundle_valid  = 1'b1;
                bundle.end_ev = 1'b1;
                phase_nxt     = lsis_pkg::PH_IDLE;
                elapsed_nxt   = '0;
                qualify_nxt   = '0;
                sidx_nxt      = '0;
                gap_nxt       = '0;
              end else begin
                phase_nxt = lsis_pkg::PH_GAP;
                gap_nxt   = gap_cur + 18'd1;
              end
            end else begin
              // Gap done: send the next string.
              bundle_valid = 1'b1;
              bundle.chars = 1'b1;
              phase_nxt    = lsis_pkg::PH_WAIT_TX;
              gap_nxt      = '0;
              sidx_nxt     = sidx_inc;
              if ({1'b0, sidx_inc} >= {1'b0, cnt, 1'b0}) begin
                bundle.end_ev = 1'b1;
                phase_nxt     = lsis_pkg::PH_IDLE;
                elapsed_nxt   = '0;
                qualify_nxt   = '0;
                sidx_nxt      = '0;
              end
            end
          end
        end
        default: begin
          // Idle: qualify the window.
          phase_nxt = lsis_pkg::PH_IDLE;
          if (win_ok) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc > {2'd0, cfg.period_us}) begin
              elapsed_nxt = '0;
              qualify_nxt = qualify_inc;
              if (qualify_inc > cfg.hold_count) begin
                qualify_nxt = '0;
                sidx_nxt    = '0;
                gap_nxt     = '0;
                phase_nxt   = lsis_pkg::PH_WAIT_TX;
              end
            end
          end else begin
            elapsed_nxt = '0;
            qualify_nxt = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lsis_pkg::PH_IDLE;
      elapsed_r <= '0;
      qualify_r <= '0;
      sidx_r    <= '0;
      gap_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      qualify_r <= qualify_nxt;
      sidx_r    <= sidx_nxt;
      gap_r     <= gap_nxt;
    end
  end

endmodule

FILE: rtl/core/lsis_emit.sv
module lsis_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              bundle_valid,
  input  lsis_pkg::bundle_t bundle,
  output logic              emit_ready,
  lsis_out_if.source        out_ch
);

  lsis_pkg::bundle_t bundle_r, bundle_nxt;
  logic              busy_r, busy_nxt;
  logic [2:0]        pos_r, pos_nxt;
  logic              is_char;
  logic              is_last;
  logic              out_fire;

  // Current result from the held bundle.
  assign is_char = bundle_r.chars && (pos_r < 3'd4);
  assign is_last = !is_char || (!bundle_r.end_ev && pos_r == 3'd3);

  assign out_ch.valid      = busy_r;
  assign out_ch.event_kind = is_char ? lsis_pkg::EV_CHAR : lsis_pkg::EV_END;
  assign out_ch.char_byte  = is_char ? lsis_pkg::lic_char(bundle_r.sel, pos_r[1:0]) : 8'd0;
  assign out_ch.last       = is_last;

  assign out_fire   = busy_r && out_ch.ready;
  assign emit_ready = !busy_r || (out_fire && is_last);

  // Step through the bundle, or load the next one when idle or as the last result leaves.
  always_comb begin
    bundle_nxt = bundle_r;
    busy_nxt   = busy_r;
    pos_nxt    = pos_r;
    if (out_fire) begin
      pos_nxt = pos_r + 3'd1;
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (emit_ready && bundle_valid) begin
      bundle_nxt = bundle;
      busy_nxt   = 1'b1;
      pos_nxt    = bundle.chars ? 3'd0 : 3'd4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bundle_r <= bundle_nxt;
  end

endmodule

FILE: rtl/core/license_string_injection_sequencer_top.sv
// Channel | Direction | Payload                                              | Handshake
// in_ch   | in        | sector, gfs_set, soct_on, disc_has_data, tx_idle     | valid/ready
// out_ch  | out       | event_kind, char_byte, last                          | valid/ready
// cfg     | in        | six registers at byte address 4*index                | APB, pready high
//
// A request that causes no result is taken one per cycle while no results are pending.
// A request that causes results loads the result register; the results then leave one
// per cycle from it while out_ch is ready (one, four or five), and the next request is
// taken in the cycle the last of them is taken.
// Reset is synchronous on rst_n and returns the sequencer to idle with default registers.
// A stalled out_ch holds in_ch.ready low only while results are pending.
module license_string_injection_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  lsis_in_if.sink     in_ch,
  lsis_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lsis_pkg::cfg_t    cfg;
  lsis_pkg::bundle_t bundle;
  logic              bundle_valid;
  logic              emit_ready;

  // Register file.
  lsis_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Qualify and burst sequencer.
  lsis_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .cfg          (cfg),
    .emit_ready   (emit_ready),
    .bundle_valid (bundle_valid),
    .bundle       (bundle)
  );

  // Result serializer.
  lsis_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .bundle_valid (bundle_valid),
    .bundle       (bundle),
    .emit_ready   (emit_ready),
    .out_ch       (out_ch)
  );

endmodule
